@@ rtl/dnslcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnslcd_pkg
// Shared types and constants of the dual-number segment LCD renderer: reading
// and queue entry types, per-stage row records, image type and digit masks.
// ----------------------------------------------------------------------------
package dnslcd_pkg;

  localparam int DRAWN_BYTES = 14;
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [14:0] reading_t;

  localparam reading_t SAT_MIN = -15'sd999;
  localparam reading_t SAT_MAX = 15'sd9999;

  typedef struct packed {
    reading_t upper;
    reading_t lower;
  } entry_t;

  typedef struct packed {
    logic        neg;
    logic        one;
    logic        div;
    logic [13:0] n1;
    logic [9:0]  q;
  } scale_t;

  typedef struct packed {
    logic       neg;
    logic       one;
    logic       point;
    logic [9:0] m;
    logic [6:0] t1;
    logic [3:0] h;
  } split_t;

  typedef struct packed {
    logic       neg;
    logic       point;
    logic       en0;
    logic       en1;
    logic [3:0] d0;
    logic [3:0] d1;
    logic [3:0] d2;
  } digits_t;

  typedef logic [DRAWN_BYTES-1:0][7:0] image_t;

  // Image byte offsets and masks
  localparam int UNIT_BYTE = 7;
  localparam logic [7:0] UNIT_MASK = 8'h03;
  localparam int UPPER_MINUS_BYTE = 3;
  localparam logic [7:0] UPPER_MINUS_MASK = 8'h24;
  localparam int UPPER_POINT_BYTE = 5;
  localparam logic [7:0] UPPER_POINT_MASK = 8'h02;
  localparam int LOWER_MINUS_BYTE = 8;
  localparam logic [7:0] LOWER_MINUS_MASK = 8'h42;
  localparam int LOWER_POINT_BYTE = 11;
  localparam logic [7:0] LOWER_POINT_MASK = 8'h20;
  localparam int UPPER_BASE = 0;
  localparam int LOWER_BASE = 3;

  localparam int PLACE_ROW [6] = '{2, 4, 5, 7, 9, 11};

  // Three mask bytes per digit, first byte in the top bits; digit 9 first
  localparam logic [9:0][23:0] MASK_P0 = {
    24'h05FFC0, 24'h07FFC0, 24'h008FC0, 24'h07FF80, 24'h05FF80,
    24'h04E7C0, 24'h05BFC0, 24'h07BDC0, 24'h0007C0, 24'h07DFC0};
  localparam logic [9:0][23:0] MASK_P1 = {
    24'h1FFC80, 24'h3FFC80, 24'h00FC80, 24'h3FF880, 24'h1FF880,
    24'h0EF480, 24'h17FC80, 24'h37DC80, 24'h007480, 24'h3DFC80};
  localparam logic [9:0][23:0] MASK_P2 = {
    24'h016FF4, 24'h017FF4, 24'h000CF4, 24'h017F74, 24'h016F74,
    24'h006AF4, 24'h012FF4, 24'h013FD4, 24'h0000F4, 24'h017DF4};
  localparam logic [9:0][23:0] MASK_P3 = {
    24'h005FFC, 24'h007FFC, 24'h0008FC, 24'h007FF8, 24'h005FF8,
    24'h004E7C, 24'h005BFC, 24'h007BDC, 24'h00007C, 24'h007DFC};
  localparam logic [9:0][23:0] MASK_P4 = {
    24'h01FFC8, 24'h03FFC8, 24'h000FC8, 24'h03FF88, 24'h01FF88,
    24'h00EF48, 24'h017FC8, 24'h037DC8, 24'h000748, 24'h03DFC8};
  localparam logic [9:0][23:0] MASK_P5 = {
    24'h16FF40, 24'h17FF40, 24'h00CF40, 24'h17F740, 24'h16F740,
    24'h06AF40, 24'h12FF40, 24'h13FD40, 24'h000F40, 24'h17DF40};

  function automatic logic [23:0] digit_mask(input int place, input logic [3:0] digit);
    logic [23:0] mask;
    case (place)
      0: mask = MASK_P0[digit];
      1: mask = MASK_P1[digit];
      2: mask = MASK_P2[digit];
      3: mask = MASK_P3[digit];
      4: mask = MASK_P4[digit];
      5: mask = MASK_P5[digit];
      default: mask = 24'h000000;
    endcase
    return mask;
  endfunction

endpackage
`default_nettype wire

@@ rtl/dual_number_segment_lcd_renderer.sv @@
`default_nettype none
// A changed reading passes the queue, the scale/split/digit registers and the emit register.
// Redraws are limited by the output, which sends one byte per cycle while out_ready is high.
// A reading that leaves the shown pair unchanged is accepted and yields no bytes.
// Input is taken every cycle while the 2-entry redraw queue has room.
// Reset clears the shown pair to zero and empties the queue, pipeline and output.
// ----------------------------------------------------------------------------
// dual_number_segment_lcd_renderer
// Renders outdoor and indoor/CO2 readings into a segment LCD image and streams
// the image bytes whenever the shown indoor/outdoor pair changes.
// ----------------------------------------------------------------------------
module dual_number_segment_lcd_renderer #(
  parameter int IMAGE_BYTES = 14
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [14:0] outdoor_value,
  input  wire logic signed [14:0] indoor_value,
  input  wire logic signed [14:0] co2_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [3:0]              segment_index,
  output logic [7:0]              segment_byte,
  output logic                    last
);

  logic                queue_full;
  logic                push;
  dnslcd_pkg::entry_t  push_data;
  logic                pop;
  dnslcd_pkg::entry_t  head;
  logic                head_valid;
  dnslcd_pkg::image_t  image;
  logic                image_valid;
  logic                image_ready;

  dnslcd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .outdoor_value (outdoor_value),
    .indoor_value  (indoor_value),
    .co2_value     (co2_value),
    .queue_full    (queue_full),
    .push          (push),
    .push_data     (push_data)
  );

  dnslcd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  dnslcd_render u_render (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .head_pop    (pop),
    .image       (image),
    .image_valid (image_valid),
    .image_ready (image_ready)
  );

  dnslcd_emit #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .image         (image),
    .image_valid   (image_valid),
    .image_ready   (image_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .segment_index (segment_index),
    .segment_byte  (segment_byte),
    .last          (last)
  );

`ifndef ASSERT_OFF
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> segment_index == 4'(IMAGE_BYTES - 1))
    else $error("last marks a byte other than the final index");

  a_index_advance: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && segment_index == $past(segment_index) + 4'd1)
    else $error("image byte stream broke before its final byte");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || segment_index == 4'd0)
    else $error("new image does not start at index zero");

  a_unit_icons: assert property (@(posedge clk) disable iff (rst)
    out_valid && segment_index == 4'd7 |-> segment_byte[1:0] == 2'b11)
    else $error("unit icons missing from byte 7");
`endif

endmodule
`default_nettype wire

@@ rtl/dnslcd_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnslcd_front
// Accepts readings, saturates them, compares indoor/outdoor with the shown
// pair and pushes a redraw entry (upper and lower number) into the queue.
// ----------------------------------------------------------------------------
module dnslcd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic signed [14:0]   outdoor_value,
  input  wire logic signed [14:0]   indoor_value,
  input  wire logic signed [14:0]   co2_value,
  input  wire logic                 queue_full,
  output logic                      push,
  output dnslcd_pkg::entry_t        push_data
);

  function automatic dnslcd_pkg::reading_t sat(input dnslcd_pkg::reading_t v);
    dnslcd_pkg::reading_t r;
    if (v < dnslcd_pkg::SAT_MIN) begin
      r = dnslcd_pkg::SAT_MIN;
    end else if (v > dnslcd_pkg::SAT_MAX) begin
      r = dnslcd_pkg::SAT_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  dnslcd_pkg::reading_t shown_outdoor;
  dnslcd_pkg::reading_t shown_indoor;
  dnslcd_pkg::reading_t sat_outdoor;
  dnslcd_pkg::reading_t sat_indoor;
  dnslcd_pkg::reading_t sat_co2;
  logic                 accept;
  logic                 changed;

  always_comb begin
    sat_outdoor = sat(outdoor_value);
    sat_indoor  = sat(indoor_value);
    sat_co2     = sat(co2_value);
    in_ready    = !queue_full;
    accept      = in_valid && in_ready;
    changed     = (sat_outdoor != shown_outdoor) || (sat_indoor != shown_indoor);
    push        = accept && changed;
    push_data.upper = sat_outdoor;
    push_data.lower = (sat_co2 != 15'sd0) ? sat_co2 : sat_indoor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shown_outdoor <= '0;
      shown_indoor  <= '0;
    end else if (push) begin
      shown_outdoor <= sat_outdoor;
      shown_indoor  <= sat_indoor;
    end
  end

endmodule
`default_nettype wire

@@ rtl/dnslcd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnslcd_queue
// Short FIFO of redraw entries between the front and the renderer.
// ----------------------------------------------------------------------------
module dnslcd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire dnslcd_pkg::entry_t  push_data,
  output logic                     full,
  input  wire logic                pop,
  output dnslcd_pkg::entry_t       head,
  output logic                     head_valid
);

  localparam int PW = $clog2(dnslcd_pkg::QUEUE_DEPTH);

  dnslcd_pkg::entry_t entries [dnslcd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]      wr_ptr;
  logic [PW-1:0]      rd_ptr;
  logic [PW:0]        count;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(dnslcd_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PW'(1);
    end
    return r;
  endfunction

  assign full       = (count == (PW+1)'(dnslcd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/dnslcd_render.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnslcd_render
// Three-stage pipeline that turns an upper and a lower number into a segment
// image: scale down by ten when too wide, split into digits, then draw the masks.
// ----------------------------------------------------------------------------
module dnslcd_render (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dnslcd_pkg::entry_t  head,
  input  wire logic                head_valid,
  output logic                     head_pop,
  output dnslcd_pkg::image_t       image,
  output logic                     image_valid,
  input  wire logic                image_ready
);

  function automatic dnslcd_pkg::scale_t scale_row(input dnslcd_pkg::reading_t v);
    dnslcd_pkg::scale_t s;
    logic [13:0]        n;
    logic [26:0]        prod;
    s.neg  = v[14];
    n      = s.neg ? 14'(-v) : 14'(v);
    s.one  = s.neg && (n >= 14'd100) && (n <= 14'd199);
    s.n1   = s.one ? (n - 14'd100) : n;
    s.div  = s.neg ? (s.n1 > 14'd99) : (s.n1 > 14'd999);
    prod   = 27'(s.n1) * 27'd6554;
    s.q    = prod[25:16];
    return s;
  endfunction

  function automatic dnslcd_pkg::split_t split_row(input dnslcd_pkg::scale_t s);
    dnslcd_pkg::split_t p;
    logic [17:0]        p_tens;
    logic [15:0]        p_hund;
    p.neg   = s.neg;
    p.one   = s.one;
    p.point = !s.div;
    p.m     = s.div ? s.q : s.n1[9:0];
    p_tens  = 18'(p.m) * 18'd205;
    p_hund  = 16'(p.m) * 16'd41;
    p.t1    = p_tens[17:11];
    p.h     = p_hund[15:12];
    return p;
  endfunction

  function automatic dnslcd_pkg::digits_t digits_row(input dnslcd_pkg::split_t p);
    dnslcd_pkg::digits_t d;
    logic [9:0]          units;
    logic [6:0]          tens;
    units   = p.m - ((10'(p.t1) << 3) + (10'(p.t1) << 1));
    tens    = p.t1 - ((7'(p.h) << 3) + (7'(p.h) << 1));
    d.neg   = p.neg;
    d.point = p.point;
    d.en0   = p.neg ? p.one : (p.m > 10'd99);
    d.d0    = p.neg ? 4'd1 : p.h;
    d.en1   = (p.m > 10'd9) || p.point;
    d.d1    = tens[3:0];
    d.d2    = units[3:0];
    return d;
  endfunction

  function automatic dnslcd_pkg::image_t put_digit(input dnslcd_pkg::image_t img,
                                                    input int place,
                                                    input logic [3:0] digit);
    dnslcd_pkg::image_t r;
    logic [23:0]        mask;
    int                 row;
    r    = img;
    mask = dnslcd_pkg::digit_mask(place, digit);
    row  = dnslcd_pkg::PLACE_ROW[place];
    r[row]     = r[row] | mask[23:16];
    r[row + 1] = r[row + 1] | mask[15:8];
    r[row + 2] = r[row + 2] | mask[7:0];
    return r;
  endfunction

  function automatic dnslcd_pkg::image_t draw_row(input dnslcd_pkg::image_t img,
                                                   input dnslcd_pkg::digits_t d,
                                                   input int base,
                                                   input int mi,
                                                   input logic [7:0] mm,
                                                   input int pi,
                                                   input logic [7:0] pm);
    dnslcd_pkg::image_t r;
    r = img;
    if (d.neg) begin
      r[mi] = r[mi] | mm;
    end
    if (d.point) begin
      r[pi] = r[pi] | pm;
    end
    if (d.en0) begin
      r = put_digit(r, base, d.d0);
    end
    if (d.en1) begin
      r = put_digit(r, base + 1, d.d1);
    end
    r = put_digit(r, base + 2, d.d2);
    return r;
  endfunction

  logic                v1, v2, v3;
  logic                ready1, ready2, ready3;
  dnslcd_pkg::scale_t  s1_upper, s1_lower;
  dnslcd_pkg::split_t  s2_upper, s2_lower;
  dnslcd_pkg::digits_t s3_upper, s3_lower;
  dnslcd_pkg::image_t  base_image;

  always_comb begin
    ready3   = !v3 || image_ready;
    ready2   = !v2 || ready3;
    ready1   = !v1 || ready2;
    head_pop = head_valid && ready1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= head_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_upper <= scale_row(head.upper);
      s1_lower <= scale_row(head.lower);
    end
    if (ready2 && v1) begin
      s2_upper <= split_row(s1_upper);
      s2_lower <= split_row(s1_lower);
    end
    if (ready3 && v2) begin
      s3_upper <= digits_row(s2_upper);
      s3_lower <= digits_row(s2_lower);
    end
  end

  always_comb begin
    base_image = '0;
    base_image[dnslcd_pkg::UNIT_BYTE] = dnslcd_pkg::UNIT_MASK;
    image = draw_row(base_image, s3_upper, dnslcd_pkg::UPPER_BASE,
                     dnslcd_pkg::UPPER_MINUS_BYTE, dnslcd_pkg::UPPER_MINUS_MASK,
                     dnslcd_pkg::UPPER_POINT_BYTE, dnslcd_pkg::UPPER_POINT_MASK);
    image = draw_row(image, s3_lower, dnslcd_pkg::LOWER_BASE,
                     dnslcd_pkg::LOWER_MINUS_BYTE, dnslcd_pkg::LOWER_MINUS_MASK,
                     dnslcd_pkg::LOWER_POINT_BYTE, dnslcd_pkg::LOWER_POINT_MASK);
    image_valid = v3;
  end

endmodule
`default_nettype wire

@@ rtl/dnslcd_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dnslcd_emit
// Holds one rendered image and sends its bytes in index order, one byte per
// cycle while out_ready is high, marking the final byte.
// ----------------------------------------------------------------------------
module dnslcd_emit #(
  parameter int IMAGE_BYTES = 14
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dnslcd_pkg::image_t  image,
  input  wire logic                image_valid,
  output logic                     image_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               segment_index,
  output logic [7:0]               segment_byte,
  output logic                     last
);

  localparam int CW = $clog2(IMAGE_BYTES);

  logic [IMAGE_BYTES-1:0][7:0] fill;
  logic [IMAGE_BYTES-1:0][7:0] shift_bytes;
  logic [CW-1:0]               idx;
  logic                        load;
  logic                        send;

  for (genvar g = 0; g < IMAGE_BYTES; g++) begin : g_fill
    if (g < dnslcd_pkg::DRAWN_BYTES) begin : g_drawn
      assign fill[g] = image[g];
    end else begin : g_blank
      assign fill[g] = 8'h00;
    end
  end

  always_comb begin
    last          = (idx == CW'(IMAGE_BYTES - 1));
    send          = out_valid && out_ready;
    image_ready   = !out_valid || (out_ready && last);
    load          = image_valid && image_ready;
    segment_index = 4'(idx);
    segment_byte  = shift_bytes[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= '0;
    end else if (send) begin
      if (last) begin
        out_valid <= 1'b0;
      end else begin
        idx <= idx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shift_bytes <= fill;
    end else if (send) begin
      shift_bytes <= shift_bytes >> 8;
    end
  end

endmodule
`default_nettype wire
